FILE: design/ucd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
package ucd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrogateLo = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Min2Byte    = 21'h000080;
  localparam logic [CpWidth-1:0] Min3Byte    = 21'h000800;
  localparam logic [CpWidth-1:0] Min4Byte    = 21'h010000;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;

  // Number of results one byte causes: 0..4; a queued burst holds 1..4.
  typedef logic [2:0] burst_cnt_t;

  // One queued burst: count-1 replacement words followed by one final word.
  typedef struct packed {
    burst_cnt_t         count;
    logic [CpWidth-1:0] last_cp;
    logic               last_rep;
    logic               eot;
  } burst_t;

endpackage

FILE: design/ucd_if.sv
// Stream interfaces for the decoder's byte input and code point output.
interface ucd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ucd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;
  logic        text_done;

  modport source (output valid, output code_point, output replaced,
                  output last_of_run, output text_done, input ready);
  modport sink   (input valid, input code_point, input replaced,
                  input last_of_run, input text_done, output ready);
endinterface

FILE: design/ucd_front.sv
// Front end: classifies each byte, tracks the open sequence, emits burst descriptors.
module ucd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_text_i,
  input  logic            full_i,
  output logic            push_o,
  output ucd_pkg::burst_t burst_o
);

  logic [1:0]  exp_q, exp_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] part_q, part_d;

  logic        accept;
  logic        is_cont;
  logic [20:0] v;
  logic        v_bad;
  logic [20:0] minimum;

  logic        f_out;
  logic [20:0] f_cp;
  logic        f_rep;
  logic [1:0]  f_exp;
  logic [20:0] f_part;

  ucd_pkg::burst_cnt_t cnt;
  logic [20:0]         cp;
  logic                rep;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  assign is_cont = (in_byte_i & ucd_pkg::ContMask) == ucd_pkg::ContTag;
  assign v       = {part_q[14:0], in_byte_i[5:0]};

  always_comb begin
    case (exp_q)
      2'd1:    minimum = ucd_pkg::Min2Byte;
      2'd2:    minimum = ucd_pkg::Min3Byte;
      default: minimum = ucd_pkg::Min4Byte;
    endcase
  end

  assign v_bad = (v < minimum) || (v > ucd_pkg::MaxScalar) ||
                 ((v >= ucd_pkg::SurrogateLo) && (v <= ucd_pkg::SurrogateHi));

  // Decode the byte as a fresh lead.
  always_comb begin
    f_out  = 1'b0;
    f_cp   = ucd_pkg::Replacement;
    f_rep  = 1'b1;
    f_exp  = 2'd0;
    f_part = '0;
    if (!in_byte_i[7]) begin
      f_out = 1'b1;
      f_cp  = {13'd0, in_byte_i};
      f_rep = 1'b0;
    end else if ((in_byte_i & ucd_pkg::Lead2Mask) == ucd_pkg::Lead2Tag) begin
      f_exp  = 2'd1;
      f_part = {16'd0, in_byte_i[4:0]};
    end else if ((in_byte_i & ucd_pkg::Lead3Mask) == ucd_pkg::Lead3Tag) begin
      f_exp  = 2'd2;
      f_part = {17'd0, in_byte_i[3:0]};
    end else if ((in_byte_i & ucd_pkg::Lead4Mask) == ucd_pkg::Lead4Tag) begin
      f_exp  = 2'd3;
      f_part = {18'd0, in_byte_i[2:0]};
    end else begin
      f_out = 1'b1;
    end
    // A lead that is the last byte of the text fails at once.
    if ((f_exp != 2'd0) && end_of_text_i) begin
      f_out = 1'b1;
    end
  end

  always_comb begin
    exp_d  = exp_q;
    held_d = held_q;
    part_d = part_q;
    cnt    = '0;
    cp     = ucd_pkg::Replacement;
    rep    = 1'b1;
    if (exp_q == 2'd0) begin
      cnt    = {2'd0, f_out};
      cp     = f_cp;
      rep    = f_rep;
      exp_d  = f_exp;
      part_d = f_part;
      held_d = 2'd0;
    end else if (is_cont) begin
      if (({1'b0, held_q} + 3'd1) >= {1'b0, exp_q}) begin
        if (v_bad) begin
          cnt = {1'b0, held_q} + 3'd2;
        end else begin
          cnt = 3'd1;
          cp  = v;
          rep = 1'b0;
        end
        exp_d  = 2'd0;
        held_d = 2'd0;
        part_d = '0;
      end else begin
        held_d = held_q + 2'd1;
        part_d = v;
        if (end_of_text_i) begin
          cnt = {1'b0, held_q} + 3'd2;
        end
      end
    end else begin
      // Flush lead and held continuations, then handle the byte anew.
      cnt    = {1'b0, held_q} + 3'd1 + {2'd0, f_out};
      exp_d  = f_exp;
      part_d = f_part;
      held_d = 2'd0;
      if (f_out) begin
        cp  = f_cp;
        rep = f_rep;
      end
    end
    if (end_of_text_i) begin
      exp_d  = 2'd0;
      held_d = 2'd0;
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 2'd0;
      held_q <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      exp_q  <= exp_d;
      held_q <= held_d;
      part_q <= part_d;
    end
  end

  assign push_o           = accept && (cnt != 3'd0);
  assign burst_o.count    = cnt;
  assign burst_o.last_cp  = cp;
  assign burst_o.last_rep = rep;
  assign burst_o.eot      = end_of_text_i;

endmodule

FILE: design/ucd_queue.sv
// Burst queue between the front end and the result sequencer.
module ucd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ucd_pkg::burst_t data_i,
  input  logic            pop_i,
  output ucd_pkg::burst_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ucd_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/ucd_back.sv
// Back end: expands each burst into result words and holds them in an output register.
module ucd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ucd_pkg::burst_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [20:0]     code_point_o,
  output logic            replaced_o,
  output logic            last_of_run_o,
  output logic            text_done_o
);

  logic [1:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic [20:0] cp_q;
  logic        rep_q, last_q, done_q;
  logic        load, emit, is_last;

  assign load    = !vld_q || ready_i;
  assign emit    = load && !empty_i;
  assign is_last = ({1'b0, idx_q} + 3'd1) == head_i.count;
  assign pop_o   = emit && is_last;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      vld_d = !empty_i;
    end
    if (emit) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // Leading words of a burst are replacements; the last carries the stored value.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cp_q   <= is_last ? head_i.last_cp : ucd_pkg::Replacement;
      rep_q  <= is_last ? head_i.last_rep : 1'b1;
      last_q <= is_last;
      done_q <= is_last && head_i.eot;
    end
  end

  assign valid_o       = vld_q;
  assign code_point_o  = cp_q;
  assign replaced_o    = rep_q;
  assign last_of_run_o = last_q;
  assign text_done_o   = done_q;

endmodule

FILE: design/utf8_codepoint_decoder.sv
// Top level of the streaming UTF-8 to code point decoder.
// One byte is taken per cycle whenever the burst queue has room; a byte never
// waits on the result side directly. Each byte yields zero to four result words,
// and the back end sends one word per cycle while the sink is ready. The queue of
// QueueDepth bursts absorbs replay bursts; sustained input rate is one byte per
// cycle while words per byte averages one and the sink stays ready. Malformed
// input yields U+FFFD words with replaced set; each burst passes through the queue
// memory and then the back end's output register before it is seen.
module utf8_codepoint_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ucd_in_if.sink    in_i,
  ucd_out_if.source out_o
);

  logic            push, pop, empty, full;
  ucd_pkg::burst_t burst, head;

  ucd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .full_i        (full),
    .push_o        (push),
    .burst_o       (burst)
  );

  ucd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (burst),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  ucd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .code_point_o  (out_o.code_point),
    .replaced_o    (out_o.replaced),
    .last_of_run_o (out_o.last_of_run),
    .text_done_o   (out_o.text_done)
  );

endmodule

FILE: sim/tb.sv
// Testbench for the UTF-8 code point decoder: directed and random byte texts.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CpW = ucd_pkg::CpWidth;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic           last_of_run;
    logic           text_done;
  } cp_word_t;

  logic clk = 1'b0;
  logic rst_n;

  ucd_in_if  in_bus ();
  ucd_out_if out_bus ();

  utf8_codepoint_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as the predictor tracks it.
  logic [1:0]     seq_need;
  logic [1:0]     seq_held;
  logic [CpW-1:0] seq_value;

  cp_word_t step_words [4];
  int       step_count;
  cp_word_t expected_words [$];

  int  fail_count;
  int  bytes_sent;
  bit  source_idle;
  bit  sink_idle;
  int  stall_cycles;

  function automatic int draw_gap(bit enabled);
    if (!enabled) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  task automatic clear_sequence();
    seq_need  = 2'd0;
    seq_held  = 2'd0;
    seq_value = '0;
  endtask

  task automatic queue_expected(cp_word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic emit_word(logic [CpW-1:0] cp, logic rep);
    if (step_count < 4) begin
      step_words[step_count] = '{code_point: cp, replaced: rep,
                                 last_of_run: 1'b0, text_done: 1'b0};
      step_count++;
    end
  endtask

  // Replace the lead and every held continuation, then go idle.
  task automatic flush_open_sequence();
    int i;
    emit_word(ucd_pkg::Replacement, 1'b1);
    for (i = 0; i < ((seq_held > 2) ? 2 : seq_held); i++)
      emit_word(ucd_pkg::Replacement, 1'b1);
    clear_sequence();
  endtask

  task automatic decode_fresh(logic [7:0] b, logic eot);
    if (b < 8'h80) begin
      emit_word({13'd0, b}, 1'b0);
    end else begin
      if ((b & ucd_pkg::Lead2Mask) == ucd_pkg::Lead2Tag) begin
        seq_need  = 2'd1;
        seq_value = {16'd0, b[4:0]};
      end else if ((b & ucd_pkg::Lead3Mask) == ucd_pkg::Lead3Tag) begin
        seq_need  = 2'd2;
        seq_value = {17'd0, b[3:0]};
      end else if ((b & ucd_pkg::Lead4Mask) == ucd_pkg::Lead4Tag) begin
        seq_need  = 2'd3;
        seq_value = {18'd0, b[2:0]};
      end else begin
        emit_word(ucd_pkg::Replacement, 1'b1);
        return;
      end
      seq_held = 2'd0;
      if (eot) flush_open_sequence();
    end
  endtask

  task automatic predict_decode(logic [7:0] b, logic eot);
    logic [CpW-1:0] v;
    logic [CpW-1:0] minimum;
    int             i;
    step_count = 0;
    if (seq_need == 2'd0) begin
      decode_fresh(b, eot);
    end else if ((b & ucd_pkg::ContMask) == ucd_pkg::ContTag) begin
      v = {seq_value[CpW-7:0], b[5:0]};
      if (int'(seq_held) + 1 >= int'(seq_need)) begin
        minimum = (seq_need == 2'd1) ? ucd_pkg::Min2Byte
                : (seq_need == 2'd2) ? ucd_pkg::Min3Byte : ucd_pkg::Min4Byte;
        if (v < minimum || v > ucd_pkg::MaxScalar ||
            (v >= ucd_pkg::SurrogateLo && v <= ucd_pkg::SurrogateHi)) begin
          flush_open_sequence();
          emit_word(ucd_pkg::Replacement, 1'b1);
        end else begin
          emit_word(v, 1'b0);
          clear_sequence();
        end
      end else begin
        seq_held  = seq_held + 2'd1;
        seq_value = v;
        if (eot) flush_open_sequence();
      end
    end else begin
      flush_open_sequence();
      decode_fresh(b, eot);
    end
    if (eot) clear_sequence();
    if (step_count > 0) begin
      step_words[step_count-1].last_of_run = 1'b1;
      step_words[step_count-1].text_done   = eot;
    end
    for (i = 0; i < step_count; i++) queue_expected(step_words[i]);
  endtask

  // Present one byte after a random gap when source_idle is set, hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    gap = draw_gap(source_idle);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.in_byte     <= b;
    in_bus.end_of_text <= eot;
    do @(posedge clk); while (!in_bus.ready);
    predict_decode(b, eot);
    bytes_sent++;
  endtask

  // Encode cp in len bytes and send the first keep of them.
  task automatic send_scalar(logic [CpW-1:0] cp, int len, int keep, bit eot_last);
    logic [7:0] seq [4];
    int         i;
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (i = 0; i < keep; i++) send_byte(seq[i], eot_last && (i == keep - 1));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(string what, cp_word_t exp_w, cp_word_t got_w);
    if (fail_count < ReportLimit)
      $display("%0t: %s exp cp=%h rep=%b last=%b done=%b got cp=%h rep=%b last=%b done=%b",
               $realtime, what, exp_w.code_point, exp_w.replaced, exp_w.last_of_run,
               exp_w.text_done, got_w.code_point, got_w.replaced, got_w.last_of_run,
               got_w.text_done);
    fail_count++;
  endtask

  // Sink side: random stall before each word when sink_idle is set.
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = draw_gap(sink_idle);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  always @(posedge clk) begin
    cp_word_t got_w;
    cp_word_t exp_w;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_w = '{code_point: out_bus.code_point, replaced: out_bus.replaced,
                last_of_run: out_bus.last_of_run, text_done: out_bus.text_done};
      if (expected_words.size() == 0) begin
        note_failure("unexpected word", '0, got_w);
      end else begin
        exp_w = expected_words.pop_front();
        if (got_w.code_point !== exp_w.code_point || got_w.replaced !== exp_w.replaced ||
            got_w.last_of_run !== exp_w.last_of_run || got_w.text_done !== exp_w.text_done)
          note_failure("word mismatch", exp_w, got_w);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_valid_sequences();
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_invalid_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_bad_values();
    // overlong, surrogate, then a 0xF5 lead that ends above the scalar range
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF5, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_broken_sequences();
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic send_random_text(int count);
    int             len;
    logic [CpW-1:0] cp;
    int             target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(1, 4);
          case (len)
            1: cp = CpW'($urandom_range(0, 'h7F));
            2: cp = CpW'($urandom_range('h80, 'h7FF));
            3: begin
              cp = CpW'($urandom_range('h800, 'hFFFF));
              if (cp >= ucd_pkg::SurrogateLo && cp <= ucd_pkg::SurrogateHi)
                cp = CpW'($urandom_range('hE000, 'hFFFF));
            end
            default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
          endcase
          send_scalar(cp, len, len, $urandom_range(0, 7) == 0);
        end
        6: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        7: begin
          // cut a valid sequence short
          len = $urandom_range(2, 4);
          cp  = CpW'((len == 2) ? $urandom_range('h80, 'h7FF)
              : (len == 3) ? $urandom_range('h800, 'hD7FF) : $urandom_range('h10000, 'h10FFFF));
          send_scalar(cp, len, $urandom_range(1, len - 1), 1'($urandom_range(0, 1)));
        end
        8: begin
          case ($urandom_range(0, 2))
            0: begin
              len = $urandom_range(2, 4);
              cp  = CpW'((len == 2) ? $urandom_range(0, 'h7F)
                  : (len == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
            end
            1: begin
              len = 3;
              cp  = CpW'($urandom_range('hD800, 'hDFFF));
            end
            default: begin
              len = 4;
              cp  = CpW'($urandom_range('h110000, 'h1FFFFF));
            end
          endcase
          send_scalar(cp, len, len, $urandom_range(0, 7) == 0);
        end
        default: send_byte(8'($urandom_range('h80, 'hBF)), 1'b0);
      endcase
    end
  endtask

  task automatic test_random_text();
    source_idle = 1'b1;
    sink_idle   = 1'b1;
    send_random_text(72);
    // full rate on both sides
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    send_random_text(60);
    // full-rate input against a stalling sink fills the burst queue
    sink_idle = 1'b1;
    send_random_text(60);
    source_idle = 1'b1;
    sink_idle   = 1'b0;
    send_random_text(40);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.in_byte     = 8'h00;
    in_bus.end_of_text = 1'b0;
    source_idle        = 1'b1;
    sink_idle          = 1'b1;
    fail_count         = 0;
    bytes_sent         = 0;
    stall_cycles       = 0;
    clear_sequence();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_ascii();
    test_valid_sequences();
    test_invalid_leads();
    test_bad_values();
    test_broken_sequences();
    wait_for_results();
    test_random_text();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ucd_pkg.sv
design/ucd_if.sv
design/ucd_front.sv
design/ucd_queue.sv
design/ucd_back.sv
design/utf8_codepoint_decoder.sv
sim/tb.sv
